/* sv/lsfe_pkg.sv */
// Shared types, constants and digit/segment helper functions for the LCD frame encoder.
`default_nettype none

package lsfe_pkg;

    localparam logic [13:0] TempMax  = 14'd9999;
    localparam logic [18:0] TimeMax  = 19'd359999;
    localparam logic [18:0] HourSecs = 19'd3600;
    localparam logic [7:0]  DashSeg  = 8'h08;
    localparam logic [7:0]  MarkBit  = 8'h80;
    localparam logic [7:0]  PointSet = 8'h01;
    localparam logic [3:0]  LastIdx  = 4'd15;

    typedef struct packed {
        logic [13:0] temp_actual;
        logic [18:0] time_actual;
        logic [13:0] temp_setpoint;
        logic [18:0] time_setpoint;
        logic        heat_icon_off;
        logic        colon_off_phase;
        logic        temp_stable;
        logic        protect_alarm;
        logic        protect_phase;
        logic        temp_set_blanked;
        logic        time_set_blanked;
    } t_in_item;

    typedef struct packed {
        logic [5:0] lcd_address;
        logic [7:0] segment_byte;
        logic       last_write;
    } t_out_item;

    typedef struct packed {
        logic heat_icon_off;
        logic colon_off_phase;
        logic temp_stable;
        logic protect_alarm;
        logic protect_phase;
        logic temp_set_blanked;
        logic time_set_blanked;
    } t_flags;

    // Decimal digits of one panel, ready for segment lookup.
    typedef struct packed {
        logic [3:0] d_thou;
        logic [3:0] d_hund;
        logic [3:0] d_tens;
        logic [3:0] d_ones;
        logic [6:0] hi;
        logic [5:0] lo;
        logic [3:0] hi_t;
        logic [3:0] lo_t;
        logic       is_zero;
        logic       is_long;
    } t_panel;

    typedef struct packed {
        t_panel act;
        t_panel set;
        t_flags flags;
    } t_split;

    typedef logic [15:0][7:0] t_frame;

    // v / 10 for v <= 9999 by reciprocal multiply.
    function automatic logic [9:0] div10(input logic [13:0] v);
        logic [27:0] p;
        p = 28'(v) * 28'd26215;
        return p[27:18];
    endfunction

    // v / 60 for v <= 359999.
    function automatic logic [12:0] div60_secs(input logic [18:0] v);
        logic [38:0] p;
        p = 39'(v) * 39'd559241;
        return p[37:25];
    endfunction

    // v / 60 for v <= 5999.
    function automatic logic [6:0] div60_mins(input logic [12:0] v);
        logic [26:0] p;
        p = 27'(v) * 27'd8739;
        return p[25:19];
    endfunction

    function automatic logic [3:0] rem10(input logic [13:0] v, input logic [9:0] q);
        logic [13:0] r;
        r = v - 14'({q, 3'b000}) - 14'({q, 1'b0});
        return r[3:0];
    endfunction

    function automatic logic [5:0] rem60(input logic [18:0] v, input logic [12:0] q);
        logic [18:0] r;
        r = v - 19'({q, 6'b000000}) + 19'({q, 2'b00});
        return r[5:0];
    endfunction

    function automatic logic [7:0] act_seg(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0: s = 8'h77;
            4'd1: s = 8'h24;
            4'd2: s = 8'h5D;
            4'd3: s = 8'h6D;
            4'd4: s = 8'h2E;
            4'd5: s = 8'h6B;
            4'd6: s = 8'h7B;
            4'd7: s = 8'h25;
            4'd8: s = 8'h7F;
            4'd9: s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] set_time_seg(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0: s = 8'h77;
            4'd1: s = 8'h12;
            4'd2: s = 8'h5D;
            4'd3: s = 8'h5B;
            4'd4: s = 8'h3A;
            4'd5: s = 8'h6B;
            4'd6: s = 8'h6F;
            4'd7: s = 8'h52;
            4'd8: s = 8'h7F;
            4'd9: s = 8'h7B;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] set_temp_seg(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0: s = 8'hEE;
            4'd1: s = 8'h24;
            4'd2: s = 8'hBA;
            4'd3: s = 8'hB6;
            4'd4: s = 8'h74;
            4'd5: s = 8'hD6;
            4'd6: s = 8'hDE;
            4'd7: s = 8'hA4;
            4'd8: s = 8'hFE;
            4'd9: s = 8'hF6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Alarm pattern for frame slot k (actual panel first, then set panel).
    function automatic logic [7:0] alarm_seg(input logic [3:0] k);
        logic [7:0] s;
        unique case (k)
            4'd1, 4'd4, 4'd12: s = 8'h7F;
            4'd9, 4'd11:       s = 8'hFE;
            default:           s = 8'hFF;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] slot_addr(input logic [3:0] k);
        logic [5:0] a;
        unique case (k)
            4'd8:    a = 6'd38;
            4'd9:    a = 6'd36;
            4'd10:   a = 6'd34;
            4'd11:   a = 6'd32;
            4'd12:   a = 6'd22;
            4'd13:   a = 6'd20;
            4'd14:   a = 6'd18;
            4'd15:   a = 6'd16;
            default: a = 6'({k[2:0], 1'b0});
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* sv/lsfe_digits.sv */
// Six-stage pipeline that saturates the request and splits temperatures and times into digits.
`default_nettype none

module lsfe_digits (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  lsfe_pkg::t_in_item     i_item,
    output logic                   o_valid,
    input  wire                    i_ready,
    output lsfe_pkg::t_split       o_split
);
    import lsfe_pkg::*;

    logic [5:0]  en;
    logic [5:0]  r_v;
    logic [13:0] w_t [2];
    logic [18:0] w_s [2];
    t_flags      w_f;

    // stage A: saturated inputs
    logic [13:0] r_a_t [2];
    logic [18:0] r_a_s [2];
    t_flags      r_a_f;
    // stage B
    logic [13:0] r_b_t [2];
    logic [18:0] r_b_s [2];
    logic [9:0]  r_b_q1 [2];
    logic [12:0] r_b_m [2];
    logic        r_b_zero [2];
    logic        r_b_long [2];
    t_flags      r_b_f;
    // stage C
    logic [3:0]  r_c_d3 [2];
    logic [5:0]  r_c_sec [2];
    logic [9:0]  r_c_q1 [2];
    logic [6:0]  r_c_q2 [2];
    logic [12:0] r_c_m [2];
    logic [6:0]  r_c_hr [2];
    logic        r_c_zero [2];
    logic        r_c_long [2];
    t_flags      r_c_f;
    // stage D
    logic [3:0]  r_d_d3 [2];
    logic [3:0]  r_d_d2 [2];
    logic [5:0]  r_d_sec [2];
    logic [6:0]  r_d_q2 [2];
    logic [3:0]  r_d_q3 [2];
    logic [5:0]  r_d_min [2];
    logic [6:0]  r_d_hr [2];
    logic [5:0]  r_d_mlo [2];
    logic        r_d_zero [2];
    logic        r_d_long [2];
    t_flags      r_d_f;
    // stage E
    logic [3:0]  r_e_d3 [2];
    logic [3:0]  r_e_d2 [2];
    logic [3:0]  r_e_d1 [2];
    logic [3:0]  r_e_d0 [2];
    logic [6:0]  r_e_hi [2];
    logic [5:0]  r_e_lo [2];
    logic        r_e_zero [2];
    logic        r_e_long [2];
    t_flags      r_e_f;
    // stage F
    t_panel      r_f_p [2];
    t_flags      r_f_f;

    assign w_t[0] = i_item.temp_actual;
    assign w_t[1] = i_item.temp_setpoint;
    assign w_s[0] = i_item.time_actual;
    assign w_s[1] = i_item.time_setpoint;

    always_comb begin
        w_f.heat_icon_off    = i_item.heat_icon_off;
        w_f.colon_off_phase  = i_item.colon_off_phase;
        w_f.temp_stable      = i_item.temp_stable;
        w_f.protect_alarm    = i_item.protect_alarm;
        w_f.protect_phase    = i_item.protect_phase;
        w_f.temp_set_blanked = i_item.temp_set_blanked;
        w_f.time_set_blanked = i_item.time_set_blanked;
    end

    // Advance a stage when it is empty or the stage after it advances.
    always_comb begin
        en[5] = !r_v[5] || i_ready;
        for (int k = 4; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (en & {r_v[4:0], i_valid}) | (~en & r_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int p = 0; p < 2; p++) begin
                r_a_t[p] <= (w_t[p] > TempMax) ? TempMax : w_t[p];
                r_a_s[p] <= (w_s[p] > TimeMax) ? TimeMax : w_s[p];
            end
            r_a_f <= w_f;
        end
        if (en[1]) begin
            for (int p = 0; p < 2; p++) begin
                r_b_t[p]    <= r_a_t[p];
                r_b_s[p]    <= r_a_s[p];
                r_b_q1[p]   <= div10(r_a_t[p]);
                r_b_m[p]    <= div60_secs(r_a_s[p]);
                r_b_zero[p] <= (r_a_s[p] == 19'd0);
                r_b_long[p] <= (r_a_s[p] >= HourSecs);
            end
            r_b_f <= r_a_f;
        end
        if (en[2]) begin
            for (int p = 0; p < 2; p++) begin
                r_c_d3[p]   <= rem10(r_b_t[p], r_b_q1[p]);
                r_c_sec[p]  <= rem60(r_b_s[p], r_b_m[p]);
                r_c_q1[p]   <= r_b_q1[p];
                r_c_q2[p]   <= 7'(div10(14'(r_b_q1[p])));
                r_c_m[p]    <= r_b_m[p];
                r_c_hr[p]   <= div60_mins(r_b_m[p]);
                r_c_zero[p] <= r_b_zero[p];
                r_c_long[p] <= r_b_long[p];
            end
            r_c_f <= r_b_f;
        end
        if (en[3]) begin
            for (int p = 0; p < 2; p++) begin
                r_d_d3[p]   <= r_c_d3[p];
                r_d_d2[p]   <= rem10(14'(r_c_q1[p]), 10'(r_c_q2[p]));
                r_d_sec[p]  <= r_c_sec[p];
                r_d_q2[p]   <= r_c_q2[p];
                r_d_q3[p]   <= 4'(div10(14'(r_c_q2[p])));
                r_d_min[p]  <= rem60(19'(r_c_m[p]), 13'(r_c_hr[p]));
                r_d_hr[p]   <= r_c_hr[p];
                r_d_mlo[p]  <= r_c_m[p][5:0];
                r_d_zero[p] <= r_c_zero[p];
                r_d_long[p] <= r_c_long[p];
            end
            r_d_f <= r_c_f;
        end
        if (en[4]) begin
            for (int p = 0; p < 2; p++) begin
                r_e_d3[p]   <= r_d_d3[p];
                r_e_d2[p]   <= r_d_d2[p];
                r_e_d1[p]   <= rem10(14'(r_d_q2[p]), 10'(r_d_q3[p]));
                r_e_d0[p]   <= r_d_q3[p];
                // hh:mm from an hour up, mm:ss below
                r_e_hi[p]   <= r_d_long[p] ? r_d_hr[p] : {1'b0, r_d_mlo[p]};
                r_e_lo[p]   <= r_d_long[p] ? r_d_min[p] : r_d_sec[p];
                r_e_zero[p] <= r_d_zero[p];
                r_e_long[p] <= r_d_long[p];
            end
            r_e_f <= r_d_f;
        end
        if (en[5]) begin
            for (int p = 0; p < 2; p++) begin
                r_f_p[p].d_thou  <= r_e_d0[p];
                r_f_p[p].d_hund  <= r_e_d1[p];
                r_f_p[p].d_tens  <= r_e_d2[p];
                r_f_p[p].d_ones  <= r_e_d3[p];
                r_f_p[p].hi      <= r_e_hi[p];
                r_f_p[p].lo      <= r_e_lo[p];
                r_f_p[p].hi_t    <= 4'(div10(14'(r_e_hi[p])));
                r_f_p[p].lo_t    <= 4'(div10(14'(r_e_lo[p])));
                r_f_p[p].is_zero <= r_e_zero[p];
                r_f_p[p].is_long <= r_e_long[p];
            end
            r_f_f <= r_e_f;
        end
    end

    always_comb begin
        o_split.act   = r_f_p[0];
        o_split.set   = r_f_p[1];
        o_split.flags = r_f_f;
    end

endmodule

`default_nettype wire

/* sv/lsfe_encode.sv */
// Segment lookup stage: turns both panels' digits and flags into sixteen pattern bytes.
`default_nettype none

module lsfe_encode (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  lsfe_pkg::t_split    i_split,
    output logic                o_valid,
    input  wire                 i_ready,
    output lsfe_pkg::t_frame    o_frame
);
    import lsfe_pkg::*;

    logic       r_v;
    t_frame     r_frame;
    t_frame     n_frame;
    logic [3:0] a_ho, a_lo, s_ho, s_lo;
    logic       a_colon_off;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_frame = r_frame;

    always_comb begin
        a_ho = rem10(14'(i_split.act.hi), 10'(i_split.act.hi_t));
        a_lo = rem10(14'(i_split.act.lo), 10'(i_split.act.lo_t));
        s_ho = rem10(14'(i_split.set.hi), 10'(i_split.set.hi_t));
        s_lo = rem10(14'(i_split.set.lo), 10'(i_split.set.lo_t));
        a_colon_off = !i_split.act.is_zero && i_split.flags.temp_stable
                      && i_split.flags.colon_off_phase;

        // actual panel: blank leading temperature digits
        n_frame[0] = ((i_split.act.d_thou != 4'd0) ? act_seg(i_split.act.d_thou) : 8'h00)
                     | MarkBit;
        n_frame[1] = (i_split.act.d_thou != 4'd0 || i_split.act.d_hund != 4'd0) ?
                     act_seg(i_split.act.d_hund) : 8'h00;
        n_frame[2] = act_seg(i_split.act.d_tens) | MarkBit;
        n_frame[3] = act_seg(i_split.act.d_ones)
                     | (i_split.flags.heat_icon_off ? 8'h00 : MarkBit);
        if (i_split.act.is_zero) begin
            n_frame[4] = DashSeg;
            n_frame[5] = DashSeg;
            n_frame[6] = DashSeg;
            n_frame[7] = DashSeg;
        end else begin
            n_frame[4] = act_seg(i_split.act.hi_t);
            n_frame[5] = act_seg(a_ho);
            n_frame[6] = act_seg(i_split.act.lo_t);
            n_frame[7] = act_seg(a_lo);
        end
        n_frame[6] = n_frame[6] | (a_colon_off ? 8'h00 : MarkBit);

        // set panel: blanking clears digits only, marks are ORed afterwards
        if (i_split.flags.temp_set_blanked) begin
            n_frame[8]  = 8'h00;
            n_frame[9]  = 8'h00;
            n_frame[10] = 8'h00;
            n_frame[11] = 8'h00;
        end else begin
            n_frame[8]  = (i_split.set.d_thou != 4'd0) ? set_temp_seg(i_split.set.d_thou) : 8'h00;
            n_frame[9]  = (i_split.set.d_thou != 4'd0 || i_split.set.d_hund != 4'd0) ?
                          set_temp_seg(i_split.set.d_hund) : 8'h00;
            n_frame[10] = set_temp_seg(i_split.set.d_tens);
            n_frame[11] = set_temp_seg(i_split.set.d_ones);
        end
        if (i_split.flags.time_set_blanked) begin
            n_frame[12] = 8'h00;
            n_frame[13] = 8'h00;
            n_frame[14] = 8'h00;
            n_frame[15] = 8'h00;
        end else if (i_split.set.is_zero) begin
            n_frame[12] = DashSeg;
            n_frame[13] = DashSeg;
            n_frame[14] = DashSeg;
            n_frame[15] = DashSeg;
        end else begin
            n_frame[12] = set_time_seg(i_split.set.hi_t);
            n_frame[13] = set_time_seg(s_ho);
            n_frame[14] = set_time_seg(i_split.set.lo_t);
            n_frame[15] = set_time_seg(s_lo);
        end
        n_frame[10] = n_frame[10] | PointSet;
        n_frame[13] = n_frame[13] | MarkBit;
        if (i_split.set.is_long) begin
            n_frame[15] = n_frame[15] | MarkBit;
        end else begin
            n_frame[14] = n_frame[14] | MarkBit;
        end

        // protect alarm overrides every byte
        if (i_split.flags.protect_alarm) begin
            for (int k = 0; k < 16; k++) begin
                n_frame[k] = i_split.flags.protect_phase ? alarm_seg(4'(k)) : 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_frame <= n_frame;
        end
    end

endmodule

`default_nettype wire

/* sv/lsfe_serial.sv */
// Frame buffer that plays sixteen segment RAM writes out one per cycle while the output is not stalled.
`default_nettype none

module lsfe_serial (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  lsfe_pkg::t_frame     i_frame,
    output logic                 o_valid,
    input  wire                  i_stall,
    output lsfe_pkg::t_out_item  o_item
);
    import lsfe_pkg::*;

    logic       r_v;
    logic [3:0] r_idx;
    t_frame     r_bytes;

    // Take the next frame when empty or as the last write leaves.
    assign o_ready = !r_v || (r_idx == LastIdx && !i_stall);
    assign o_valid = r_v;

    always_comb begin
        o_item.lcd_address  = slot_addr(r_idx);
        o_item.segment_byte = r_bytes[r_idx];
        o_item.last_write   = (r_idx == LastIdx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_idx <= '0;
        end else if (o_ready) begin
            r_v   <= i_valid;
            r_idx <= '0;
        end else if (!i_stall) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bytes <= i_frame;
        end
    end

endmodule

`default_nettype wire

/* sv/lcd_segment_frame_encoder.sv */
// Top level of the LCD segment frame encoder: digit pipeline, segment encoder, write serializer.
// Path: a request goes through the digit stages and the encoder register into the serializer.
// Throughput: the serializer gives one write per cycle while the output is not stalled;
//   requests are taken back to back until the pipeline's eight slots are full.
// Reset: synchronous, active low; clears all valid bits and the write counter, no clearing pass.
`default_nettype none

module lcd_segment_frame_encoder (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  lsfe_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output lsfe_pkg::t_out_item  o_out_data
);
    import lsfe_pkg::*;

    logic   dig_ready;
    logic   dig_valid;
    t_split dig_split;
    logic   enc_ready;
    logic   enc_valid;
    t_frame enc_frame;
    logic   ser_ready;

    // Saturate the request and take each temperature and time apart into
    // decimal digits, using reciprocal multiplies in place of division.
    lsfe_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (dig_ready),
        .i_item  (i_in_data),
        .o_valid (dig_valid),
        .i_ready (enc_ready),
        .o_split (dig_split)
    );

    // Map digits to segment codes per panel, OR in points, units, colon and
    // heat icon, and apply blanking and the protect alarm override.
    lsfe_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dig_valid),
        .o_ready (enc_ready),
        .i_split (dig_split),
        .o_valid (enc_valid),
        .i_ready (ser_ready),
        .o_frame (enc_frame)
    );

    // Hold one frame and step through its sixteen addresses; the next frame
    // loads in the same cycle the last write is taken.
    lsfe_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (enc_valid),
        .o_ready (ser_ready),
        .i_frame (enc_frame),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_data)
    );

    // Stall the request side only when the first digit stage cannot advance.
    assign o_in_stall = !dig_ready;

endmodule

`default_nettype wire

/* sv/lsfe_checker.sv */
// Port-level checker for the LCD segment frame encoder and its bind.
`default_nettype none

module lsfe_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input lsfe_pkg::t_in_item   i_in_data,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input lsfe_pkg::t_out_item  o_out_data
);
    import lsfe_pkg::*;

    logic out_take;

    assign out_take = o_out_valid && !i_out_stall;

    // Hold a stalled request.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled request changed or dropped");

    // Hold a stalled write.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled write changed or dropped");

    // Flag the last write exactly at the final set-panel address.
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_write == (o_out_data.lcd_address == 6'd16)))
        else $error("last_write does not match final address");

    // Within a frame the writes follow without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !o_out_data.last_write |=> o_out_valid)
        else $error("gap inside a frame");

    // A new frame starts at address zero.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && o_out_data.last_write |=> !o_out_valid || o_out_data.lcd_address == 6'd0)
        else $error("frame did not start at address zero");

endmodule

bind lcd_segment_frame_encoder lsfe_checker u_lsfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
